// ===== rtl/core/modbus_read_response_parser_core_macros.svh =====
// assertion macros shared by the parser rtl
`ifndef MODBUS_READ_RESPONSE_PARSER_CORE_MACROS_SVH
`define MODBUS_READ_RESPONSE_PARSER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define MRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mrp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrp_pkg
// Types, constants and helper functions of the Modbus read response parser.
// ----------------------------------------------------------------------------
package mrp_pkg;

    localparam logic [7:0]  FUNC_READ    = 8'd3;
    localparam logic [7:0]  BYTE_COUNT   = 8'd4;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    // ceil(2^19 / 10), exact quotient for every 16-bit dividend
    localparam logic [15:0] DIV10_RECIP  = 16'd52429;

    localparam logic [7:0] TURRET_ID_RST = 8'd1;
    localparam logic [7:0] LEFT_ID_RST   = 8'd100;
    localparam logic [7:0] RIGHT_ID_RST  = 8'd101;

    // configuration register indexes
    localparam logic [1:0] REG_TURRET_ID = 2'd0;
    localparam logic [1:0] REG_LEFT_ID   = 2'd1;
    localparam logic [1:0] REG_RIGHT_ID  = 2'd2;

    typedef logic [1:0] t_source;
    localparam t_source SRC_TURRET = 2'd0;
    localparam t_source SRC_LEFT   = 2'd1;
    localparam t_source SRC_RIGHT  = 2'd2;

    typedef struct packed {
        logic [15:0] second_value;
        logic [15:0] first_value;
        t_source     source;
    } t_result;

    // one byte of crc-16/modbus, lsb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] div10(input logic [15:0] x);
        logic [31:0] p;
        p = x * DIV10_RECIP;
        return {3'd0, p[31:19]};
    endfunction

endpackage

// ===== rtl/core/modbus_read_response_parser_core.sv =====
// ----------------------------------------------------------------------------
// modbus_read_response_parser_core
// Hunts a received byte stream for 9-byte Modbus RTU read holding register
// responses and emits the source and two 16-bit values of each good frame.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on the slave stream and gives one result
// item per good frame on the master stream. Each byte is handled as it is taken:
// id matching, frame position and the byte-wise crc update sit between
// the frame state registers, and the divide-by-ten for the turret is a
// reciprocal multiply done when the crc low byte arrives, so the result
// register is loaded on the crc high byte. A byte is taken whenever the result
// register is empty or being drained in the same cycle; a stalled master side
// stops input only while a result is waiting. Bad crc frames give no item.
`include "modbus_read_response_parser_core_macros.svh"

module modbus_read_response_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // received bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [1:0] source, [17:2] first_value,
                                        // [33:18] second_value, [39:34] zero
);

    localparam logic [3:0] POS_ID     = 4'd0;
    localparam logic [3:0] POS_FUNC   = 4'd1;
    localparam logic [3:0] POS_COUNT  = 4'd2;
    localparam logic [3:0] POS_DATA0  = 4'd3;
    localparam logic [3:0] POS_DATA1  = 4'd4;
    localparam logic [3:0] POS_DATA2  = 4'd5;
    localparam logic [3:0] POS_DATA3  = 4'd6;
    localparam logic [3:0] POS_CRC_LO = 4'd7;
    localparam logic [3:0] POS_CRC_HI = 4'd8;

    logic [7:0]  r_turret_id, r_left_id, r_right_id;
    logic [3:0]  r_pos, n_pos;
    mrp_pkg::t_source r_src, n_src;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_data0, r_data1, r_data2, r_data3;
    logic [7:0]  r_crc_lo;
    logic [15:0] r_val1, r_val2;
    logic        r_out_valid;
    mrp_pkg::t_result r_out;

    logic        in_fire;
    logic        id_hit;
    logic        frame_good;
    logic [7:0]  rx;
    logic [15:0] raw1, raw2;

    assign rx            = s_axis_tdata;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign raw1          = {r_data0, r_data1};
    assign raw2          = {r_data2, r_data3};
    assign frame_good    = (r_pos == POS_CRC_HI) && ({rx, r_crc_lo} == r_crc);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turret_id <= mrp_pkg::TURRET_ID_RST;
            r_left_id   <= mrp_pkg::LEFT_ID_RST;
            r_right_id  <= mrp_pkg::RIGHT_ID_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mrp_pkg::REG_TURRET_ID: r_turret_id <= i_cfg_data;
                mrp_pkg::REG_LEFT_ID:   r_left_id   <= i_cfg_data;
                mrp_pkg::REG_RIGHT_ID:  r_right_id  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame position, source and crc
    always_comb begin
        n_pos  = r_pos;
        n_src  = r_src;
        n_crc  = r_crc;
        id_hit = 1'b1;
        unique case (r_pos)
            POS_ID: begin
                // turret wins over left, left over right
                priority if (rx == r_turret_id) begin
                    n_src = mrp_pkg::SRC_TURRET;
                end else if (rx == r_left_id) begin
                    n_src = mrp_pkg::SRC_LEFT;
                end else if (rx == r_right_id) begin
                    n_src = mrp_pkg::SRC_RIGHT;
                end else begin
                    id_hit = 1'b0;
                end
                if (id_hit) begin
                    n_crc = mrp_pkg::crc_feed(mrp_pkg::CRC_INIT, rx);
                    n_pos = POS_FUNC;
                end
            end
            POS_FUNC: begin
                // wrong byte is skipped, position holds
                if (rx == mrp_pkg::FUNC_READ) begin
                    n_crc = mrp_pkg::crc_feed(r_crc, rx);
                    n_pos = POS_COUNT;
                end
            end
            POS_COUNT: begin
                if (rx == mrp_pkg::BYTE_COUNT) begin
                    n_crc = mrp_pkg::crc_feed(r_crc, rx);
                    n_pos = POS_DATA0;
                end
            end
            POS_DATA0, POS_DATA1, POS_DATA2, POS_DATA3: begin
                n_crc = mrp_pkg::crc_feed(r_crc, rx);
                n_pos = r_pos + 4'd1;
            end
            POS_CRC_LO: begin
                n_pos = POS_CRC_HI;
            end
            default: begin
                n_pos = POS_ID;
                n_crc = mrp_pkg::CRC_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_ID;
            r_src <= mrp_pkg::SRC_TURRET;
            r_crc <= mrp_pkg::CRC_INIT;
        end else if (in_fire) begin
            r_pos <= n_pos;
            r_src <= n_src;
            r_crc <= n_crc;
        end
    end

    // payload: data bytes, crc low byte, scaled values
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            unique case (r_pos)
                POS_DATA0: r_data0 <= rx;
                POS_DATA1: r_data1 <= rx;
                POS_DATA2: r_data2 <= rx;
                POS_DATA3: r_data3 <= rx;
                POS_CRC_LO: begin
                    r_crc_lo <= rx;
                    // data is complete here, scale ahead of the crc check
                    if (r_src == mrp_pkg::SRC_TURRET) begin
                        r_val1 <= mrp_pkg::div10(raw1);
                        r_val2 <= mrp_pkg::div10(raw2);
                    end else begin
                        r_val1 <= raw1;
                        r_val2 <= raw2;
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && frame_good) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && frame_good) begin
            r_out.source       <= r_src;
            r_out.first_value  <= r_val1;
            r_out.second_value <= r_val2;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out};

    `MRP_ASSERT_NOW(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= POS_CRC_HI,
        "frame position out of range")
    `MRP_ASSERT_NOW(a_src_legal, i_clk, i_rst_n, r_out_valid,
        r_out.source != 2'd3, "illegal source code in result")
    `MRP_ASSERT_NEXT(a_restart, i_clk, i_rst_n, in_fire && r_pos == POS_CRC_HI,
        r_pos == POS_ID && r_crc == mrp_pkg::CRC_INIT, "frame not restarted")
    `MRP_ASSERT_NOW(a_result_src, i_clk, i_rst_n, $rose(r_out_valid),
        $past(in_fire) && $past(r_pos) == POS_CRC_HI, "result without frame end")

endmodule
